@@ rtl/lrw_pkg.sv @@
// Shared types and constants for the link recovery watchdog.
// Holds the mode encoding, register indexes, pipeline structs and the
// reciprocal constants of the outage time split. No dependencies.
`default_nettype none

package lrw_pkg;

  typedef enum logic [2:0] {
    MODE_OK    = 3'd0,
    MODE_DISC  = 3'd1,
    MODE_RECON = 3'd2,
    MODE_TEST  = 3'd3,
    MODE_COOL  = 3'd4
  } mode_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_INTERVAL    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DISCONNECT_DELAY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECONNECT_TIMEOUT = 2'd2;

  localparam logic [31:0] CHECK_INTERVAL_RST    = 32'd60000;
  localparam logic [31:0] DISCONNECT_DELAY_RST  = 32'd1500;
  localparam logic [31:0] RECONNECT_TIMEOUT_RST = 32'd10000;

  // floor(x / 1000) = (x * RECIP_MS) >> 38 for every 32-bit x.
  localparam logic [28:0] RECIP_MS = 29'd274877907;
  localparam int unsigned SHIFT_MS = 38;
  // floor(s / 3600) = (s * RECIP_H) >> 33 for s below 2^23.
  localparam logic [21:0] RECIP_H  = 22'd2386093;
  localparam int unsigned SHIFT_H  = 33;
  // floor(r / 60) = (r * RECIP_M) >> 18 for r below 3600.
  localparam logic [12:0] RECIP_M  = 13'd4370;
  localparam int unsigned SHIFT_M  = 18;

  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  typedef struct packed {
    logic [31:0] check_interval_ms;
    logic [31:0] disconnect_delay_ms;
    logic [31:0] reconnect_timeout_ms;
  } cfg_t;

  // Per-poll flags that travel alongside the time split.
  typedef struct packed {
    logic  cmd_disconnect;
    logic  cmd_connect;
    logic  probe_used;
    logic  restored;
    mode_e mode_now;
  } flags_t;

  typedef struct packed {
    flags_t      flags;
    logic [31:0] outage_ms;
  } step_res_t;

endpackage

`default_nettype wire

@@ rtl/lrw_cfg.sv @@
// Configuration register file of the link recovery watchdog.
// Depends on lrw_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lrw_cfg
  import lrw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CHECK_INTERVAL:    cfg_d.check_interval_ms    = cfg_data_i;
        CFG_DISCONNECT_DELAY:  cfg_d.disconnect_delay_ms  = cfg_data_i;
        CFG_RECONNECT_TIMEOUT: cfg_d.reconnect_timeout_ms = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_interval_ms    <= CHECK_INTERVAL_RST;
      cfg_q.disconnect_delay_ms  <= DISCONNECT_DELAY_RST;
      cfg_q.reconnect_timeout_ms <= RECONNECT_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/lrw_step.sv @@
// Mode state machine of the link recovery watchdog: one poll per accepted beat.
// Depends on lrw_pkg for mode_e, cfg_t and step_res_t.
`default_nettype none

module lrw_step
  import lrw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        associated_i,
  input  wire logic        probe_ok_i,
  input  wire cfg_t        cfg_i,
  output step_res_t        res_o
);

  mode_e       mode_q, mode_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] probe_q, probe_d;
  logic [31:0] outage_q, outage_d;

  logic [31:0] since_probe, since_entry, since_outage;
  logic        healthy;

  assign since_probe  = now_ms_i - probe_q;
  assign since_entry  = now_ms_i - entry_q;
  assign since_outage = now_ms_i - outage_q;
  assign healthy      = associated_i & probe_ok_i;

  always_comb begin
    mode_d   = mode_q;
    entry_d  = entry_q;
    probe_d  = probe_q;
    outage_d = outage_q;
    res_o    = '0;
    case (mode_q)
      MODE_OK: begin
        if (since_probe >= cfg_i.check_interval_ms) begin
          probe_d              = now_ms_i;
          res_o.flags.probe_used = 1'b1;
          if (!healthy) begin
            outage_d                 = now_ms_i;
            res_o.flags.cmd_disconnect = 1'b1;
            mode_d                   = MODE_DISC;
            entry_d                  = now_ms_i;
          end
        end
      end
      MODE_DISC: begin
        if (since_entry >= cfg_i.disconnect_delay_ms) begin
          res_o.flags.cmd_connect = 1'b1;
          mode_d                  = MODE_RECON;
          entry_d                 = now_ms_i;
        end
      end
      MODE_RECON: begin
        if (associated_i) begin
          mode_d  = MODE_TEST;
          entry_d = now_ms_i;
        end else if (since_entry >= cfg_i.reconnect_timeout_ms) begin
          mode_d  = MODE_COOL;
          entry_d = now_ms_i;
        end
      end
      MODE_TEST: begin
        res_o.flags.probe_used = 1'b1;
        entry_d                = now_ms_i;
        if (healthy) begin
          res_o.flags.restored = 1'b1;
          res_o.outage_ms      = since_outage;
          probe_d              = now_ms_i;
          mode_d               = MODE_OK;
        end else begin
          mode_d = MODE_COOL;
        end
      end
      MODE_COOL: begin
        if (since_entry >= cfg_i.check_interval_ms) begin
          res_o.flags.cmd_disconnect = 1'b1;
          mode_d                     = MODE_DISC;
          entry_d                    = now_ms_i;
        end
      end
      default: begin
        mode_d = MODE_OK;
      end
    endcase
    res_o.flags.mode_now = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OK;
      entry_q  <= '0;
      probe_q  <= '0;
      outage_q <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      entry_q  <= entry_d;
      probe_q  <= probe_d;
      outage_q <= outage_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lrw_split.sv @@
// Six-stage result pipeline: splits the outage length into hours, minutes and
// seconds by reciprocal multiplication, with per-stage valid and back-pressure.
// Depends on lrw_pkg for step_res_t, flags_t and the reciprocal constants.
`default_nettype none

module lrw_split
  import lrw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire step_res_t in_res_i,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output flags_t     flags_o,
  output logic [10:0] hours_o,
  output logic [5:0]  minutes_o,
  output logic [5:0]  seconds_o
);

  localparam int unsigned Stages = 6;

  logic [Stages-1:0] valid_q, valid_d, free;

  // Stage payloads.
  flags_t      f1_q, f2_q, f3_q, f4_q, f5_q, f6_q;
  logic [31:0] ms1_q;
  logic [22:0] sec2_q, sec3_q;
  logic [10:0] hh3_q, hh4_q, hh5_q, hh6_q;
  logic [11:0] rem4_q, rem5_q;
  logic [5:0]  mm5_q, mm6_q, ss6_q;

  logic [60:0] prod_ms;
  logic [44:0] prod_h;
  logic [22:0] hh_secs;
  logic [24:0] prod_m;
  logic [11:0] mm_secs;
  logic [22:0] rem_wide;
  logic [11:0] ss_wide;

  // A stage can load when it is empty or its contents move on this cycle.
  always_comb begin
    free[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      free[k] = !valid_q[k] || free[k+1];
    end
    valid_d[0] = free[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < Stages; k++) begin
      valid_d[k] = free[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign prod_ms  = ms1_q * RECIP_MS;
  assign prod_h   = sec2_q * RECIP_H;
  assign hh_secs  = hh3_q * SECS_PER_HOUR;
  assign rem_wide = sec3_q - hh_secs;
  assign prod_m   = rem4_q * RECIP_M;
  assign mm_secs  = mm5_q * SECS_PER_MIN;
  assign ss_wide  = rem5_q - mm_secs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      f1_q  <= in_res_i.flags;
      ms1_q <= in_res_i.outage_ms;
    end
    if (free[1]) begin
      f2_q   <= f1_q;
      sec2_q <= prod_ms[SHIFT_MS +: 23];
    end
    if (free[2]) begin
      f3_q   <= f2_q;
      sec3_q <= sec2_q;
      hh3_q  <= prod_h[SHIFT_H +: 11];
    end
    if (free[3]) begin
      f4_q   <= f3_q;
      hh4_q  <= hh3_q;
      rem4_q <= rem_wide[11:0];
    end
    if (free[4]) begin
      f5_q   <= f4_q;
      hh5_q  <= hh4_q;
      rem5_q <= rem4_q;
      mm5_q  <= prod_m[SHIFT_M +: 6];
    end
    if (free[5]) begin
      f6_q  <= f5_q;
      hh6_q <= hh5_q;
      mm6_q <= mm5_q;
      ss6_q <= ss_wide[5:0];
    end
  end

  assign in_ready_o  = free[0];
  assign out_valid_o = valid_q[Stages-1];
  assign flags_o     = f6_q;
  assign hours_o     = hh6_q;
  assign minutes_o   = mm6_q;
  assign seconds_o   = ss6_q;

endmodule

`default_nettype wire

@@ rtl/link_recovery_watchdog.sv @@
// Top level of the link recovery watchdog.
// Instantiates lrw_cfg, lrw_step and lrw_split; depends on lrw_pkg.
//
// Usage. Each input beat is one poll: the current millisecond time (wrapping
// at 32 bits), whether the link is associated and the upstream probe result.
// Every poll yields exactly one result beat with the disconnect and connect
// commands, whether the probe was consulted, whether service was restored,
// the outage length as hours, minutes and seconds (zero unless restored) and
// the mode left after the poll.
//
// The mode state machine updates its state in the cycle that the input beat
// is accepted, so a new poll may be accepted every cycle while in_ready_o is
// high. The result then passes through a six-stage pipeline that splits the
// outage time by reciprocal multiplications, at most one multiply per stage.
// out_valid_o rises once the result reaches the last stage; throughput is one
// beat per cycle while out_ready_i is high.
//
// When the receiver holds out_ready_i low, the pipeline keeps filling its
// empty stages and keeps accepting polls until all six stages are occupied;
// only then does in_ready_o drop. Reset empties the pipeline, puts the mode
// in ok with all time marks at zero and loads the register reset values.
// The configuration channel is always ready and should be written while the
// block is idle.
`default_nettype none

module link_recovery_watchdog
  import lrw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // poll channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               associated_i,
  input  wire logic               probe_ok_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    cmd_disconnect_o,
  output logic                    cmd_connect_o,
  output logic                    probe_used_o,
  output logic                    restored_o,
  output logic [10:0]             outage_hours_o,
  output logic [5:0]              outage_minutes_o,
  output logic [5:0]              outage_seconds_o,
  output logic [2:0]              mode_now_o
);

  cfg_t      cfg;
  step_res_t step_res;
  flags_t    out_flags;
  logic      fire;

  // Registers are simple flops, so a write beat is always taken.
  assign cfg_ready_o = 1'b1;

  lrw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The state machine advances only on an accepted poll beat.
  assign fire = in_valid_i && in_ready_o;

  lrw_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .now_ms_i     (now_ms_i),
    .associated_i (associated_i),
    .probe_ok_i   (probe_ok_i),
    .cfg_i        (cfg),
    .res_o        (step_res)
  );

  lrw_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_res_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .flags_o     (out_flags),
    .hours_o     (outage_hours_o),
    .minutes_o   (outage_minutes_o),
    .seconds_o   (outage_seconds_o)
  );

  assign cmd_disconnect_o = out_flags.cmd_disconnect;
  assign cmd_connect_o    = out_flags.cmd_connect;
  assign probe_used_o     = out_flags.probe_used;
  assign restored_o       = out_flags.restored;
  assign mode_now_o       = out_flags.mode_now;

`ifndef ASSERT_OFF
  // Service can only come back from a successful test, which returns to ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restored_o |-> probe_used_o && (mode_now_o == MODE_OK))
    else $error("restored beat without probe or outside ok mode");

  // Outage fields stay zero unless service was restored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !restored_o |->
      (outage_hours_o == '0) && (outage_minutes_o == '0) && (outage_seconds_o == '0))
    else $error("outage length reported without restoration");

  // No poll commands both a disconnect and a connect.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cmd_disconnect_o && cmd_connect_o))
    else $error("disconnect and connect commanded together");

  // The poll channel only stalls behind a result that the receiver holds off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("poll channel stalled without back-pressure");

  // Minutes and seconds are always proper remainders.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outage_minutes_o < 6'd60) && (outage_seconds_o < 6'd60))
    else $error("outage minutes or seconds out of range");
`endif

endmodule

`default_nettype wire
